// ----- src/bbr_pkg.sv -----
// Shared types and constants for the 3x3 RGB box blur.
package bbr_pkg;

	localparam int CH_W       = 8;
	localparam int PIX_W      = 3 * CH_W;
	localparam int IMG_W_W    = 11;
	localparam int IMG_H_W    = 13;
	localparam int CFG_DATA_W = IMG_H_W;
	localparam int CNT_W      = IMG_W_W + IMG_H_W;
	localparam int SUM_W      = CH_W + 4;
	localparam int MIN_DIM    = 3;
	localparam int MAX_HEIGHT = 4096;
	localparam int OUT_DEPTH  = 4;
	localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W  = OUT_PTR_W + 1;
	localparam int DIV9_SH    = 16;
	localparam logic [DIV9_SH-1:0] DIV9_MUL = 16'd7282;

	localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 13'd480;

	localparam logic CFG_IDX_WIDTH  = 1'b0;
	localparam logic CFG_IDX_HEIGHT = 1'b1;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	typedef struct packed {
		logic emit;
		logic done;
		logic top_out;
		logic bottom_out;
		logic left_out;
		logic right_out;
	} win_flags_t;

endpackage

// ----- src/bbr_ctrl.sv -----
// Input control: configuration, raster counters, output position and remap divider.
module bbr_ctrl import bbr_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic                         in_valid,
	input  logic                         in_kind,
	input  logic [PIX_W-1:0]             in_pixel,
	input  logic                         slot_ok,
	output logic                         in_ready,
	output logic                         proc,
	output logic [$clog2(MAX_WIDTH)-1:0] col,
	output logic [PIX_W-1:0]             px,
	output win_flags_t                   flags
);
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int CMP_W     = (COL_W > IMG_W_W ? COL_W : IMG_W_W) + 1;
	localparam int WLIM      = 2 ** IMG_W_W - 1;
	localparam int MAXW_CL   = MAX_WIDTH > WLIM ? WLIM : MAX_WIDTH;
	localparam int DIV_CNT_W = $clog2(CNT_W + 1);
	localparam logic [IMG_W_W-1:0] MAXW = IMG_W_W'(MAXW_CL);

	logic [IMG_W_W-1:0]   width_q;
	logic [IMG_H_W-1:0]   height_q;
	logic [CNT_W-1:0]     total_q;
	logic [COL_W-1:0]     col_q;
	logic [1:0]           row_q;
	logic [CNT_W-1:0]     e_q;
	logic [IMG_W_W-1:0]   ec_q;
	logic [CNT_W-1:0]     er_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [IMG_W_W-1:0]   div_rem_q;
	logic [CNT_W-1:0]     div_quo_q;
	logic [CNT_W-1:0]     div_dv_q;

	logic [IMG_W_W-1:0] w_eff;
	logic [IMG_H_W-1:0] h_eff;
	logic [COL_W-1:0]   col_cur;
	logic               col_wrap;
	logic               streaming;
	logic               tail;
	logic               done;
	logic               busy;
	logic               accept;
	logic [IMG_W_W:0]   rem_sh;
	logic               q_bit;
	logic [IMG_W_W:0]   rem_nx;
	logic [CNT_W-1:0]   quo_nx;

	always_comb begin
		if (width_q < IMG_W_W'(MIN_DIM)) begin
			w_eff = IMG_W_W'(MIN_DIM);
		end else if (width_q > MAXW) begin
			w_eff = MAXW;
		end else begin
			w_eff = width_q;
		end
		if (height_q < IMG_H_W'(MIN_DIM)) begin
			h_eff = IMG_H_W'(MIN_DIM);
		end else if (height_q > IMG_H_W'(MAX_HEIGHT)) begin
			h_eff = IMG_H_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	assign col_cur   = (CMP_W'(col_q) >= CMP_W'(w_eff)) ? '0 : col_q;
	assign col_wrap  = (CMP_W'(col_cur) + CMP_W'(1)) >= CMP_W'(w_eff);
	assign streaming = (row_q == 2'd2) || (row_q == 2'd1 && col_cur != '0);
	assign tail      = streaming && ((CNT_W+1)'(e_q) + (CNT_W+1)'(w_eff) + (CNT_W+1)'(1)
		>= (CNT_W+1)'(total_q));
	assign done      = ((CNT_W+1)'(e_q) + (CNT_W+1)'(1)) >= (CNT_W+1)'(total_q);

	assign busy     = div_cnt_q != '0;
	assign in_ready = !cfg_we && !busy && slot_ok;
	assign accept   = in_valid && in_ready;
	assign proc     = accept && (in_kind == KIND_PIXEL || tail);
	assign px       = (in_kind == KIND_FLUSH) ? '0 : in_pixel;
	assign col      = col_cur;

	assign flags.emit       = streaming;
	assign flags.done       = done;
	assign flags.top_out    = er_q == '0;
	assign flags.bottom_out = ((CNT_W+1)'(er_q) + (CNT_W+1)'(1)) >= (CNT_W+1)'(h_eff);
	assign flags.left_out   = ec_q == '0;
	assign flags.right_out  = ((IMG_W_W+1)'(ec_q) + (IMG_W_W+1)'(1)) >= (IMG_W_W+1)'(w_eff);

	assign rem_sh = {div_rem_q, div_dv_q[CNT_W-1]};
	assign q_bit  = rem_sh >= (IMG_W_W+1)'(w_eff);
	assign rem_nx = q_bit ? (rem_sh - (IMG_W_W+1)'(w_eff)) : rem_sh;
	assign quo_nx = {div_quo_q[CNT_W-2:0], q_bit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IDX_WIDTH:  width_q  <= cfg_data[IMG_W_W-1:0];
				CFG_IDX_HEIGHT: height_q <= cfg_data[IMG_H_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else begin
			total_q <= CNT_W'(w_eff) * CNT_W'(h_eff);
		end
	end

	always_ff @(posedge clk) begin
		if (cfg_we) begin
			div_rem_q <= '0;
			div_quo_q <= '0;
			div_dv_q  <= e_q;
		end else if (busy) begin
			div_rem_q <= rem_nx[IMG_W_W-1:0];
			div_quo_q <= quo_nx;
			div_dv_q  <= {div_dv_q[CNT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
			col_q     <= '0;
			row_q     <= '0;
			e_q       <= '0;
			ec_q      <= '0;
			er_q      <= '0;
		end else if (cfg_we) begin
			div_cnt_q <= DIV_CNT_W'(CNT_W);
		end else if (busy) begin
			div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
			if (div_cnt_q == DIV_CNT_W'(1)) begin
				ec_q <= rem_nx[IMG_W_W-1:0];
				er_q <= quo_nx;
			end
		end else if (proc) begin
			if (streaming && done) begin
				col_q <= '0;
				row_q <= '0;
				e_q   <= '0;
				ec_q  <= '0;
				er_q  <= '0;
			end else begin
				if (col_wrap) begin
					col_q <= '0;
					if (row_q != 2'd2) begin
						row_q <= row_q + 2'd1;
					end
				end else begin
					col_q <= col_cur + COL_W'(1);
				end
				if (streaming) begin
					e_q <= e_q + CNT_W'(1);
					if (flags.right_out) begin
						ec_q <= '0;
						er_q <= er_q + CNT_W'(1);
					end else begin
						ec_q <= ec_q + IMG_W_W'(1);
					end
				end
			end
		end
	end

endmodule

// ----- src/bbr_line_buf.sv -----
// Two line stores with read-after-write bypass feeding the new window column.
module bbr_line_buf import bbr_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         proc,
	input  logic [$clog2(MAX_WIDTH)-1:0] col,
	input  logic [PIX_W-1:0]             px,
	input  win_flags_t                   flags,
	output logic                         valid_s1,
	output logic [PIX_W-1:0]             up,
	output logic [PIX_W-1:0]             mid,
	output logic [PIX_W-1:0]             px_s1,
	output win_flags_t                   flags_s1
);
	localparam int COL_W = $clog2(MAX_WIDTH);

	logic [PIX_W-1:0] older_mem [MAX_WIDTH];
	logic [PIX_W-1:0] prev_mem  [MAX_WIDTH];
	logic [PIX_W-1:0] older_rd_q;
	logic [PIX_W-1:0] prev_rd_q;
	logic [COL_W-1:0] col_s1;
	logic             byp_s1;
	logic [PIX_W-1:0] byp_up_s1;
	logic [PIX_W-1:0] byp_mid_s1;

	assign up  = byp_s1 ? byp_up_s1  : older_rd_q;
	assign mid = byp_s1 ? byp_mid_s1 : prev_rd_q;

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			older_mem[col_s1] <= mid;
		end
		older_rd_q <= older_mem[col];
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			prev_mem[col_s1] <= px_s1;
		end
		prev_rd_q <= prev_mem[col];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byp_s1   <= 1'b0;
			flags_s1 <= '0;
		end else begin
			valid_s1 <= proc;
			byp_s1   <= proc && valid_s1 && (col == col_s1);
			flags_s1 <= flags;
		end
	end

	always_ff @(posedge clk) begin
		col_s1     <= col;
		px_s1      <= px;
		byp_up_s1  <= mid;
		byp_mid_s1 <= px_s1;
	end

endmodule

// ----- src/bbr_window.sv -----
// 3x3 window registers, border-masked channel sums and division by nine.
module bbr_window import bbr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  logic [PIX_W-1:0] up,
	input  logic [PIX_W-1:0] mid,
	input  logic [PIX_W-1:0] px_s1,
	input  win_flags_t       flags_s1,
	output logic             valid_s2,
	output logic [PIX_W-1:0] res_data,
	output logic             res_last,
	output logic [1:0]       pending
);
	logic [PIX_W-1:0]          win_q [3][3];
	win_flags_t                flags_s2;
	logic [SUM_W-1:0]          sum [3];
	logic [SUM_W+DIV9_SH-1:0]  prod [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (valid_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= up;
			win_q[1][2] <= mid;
			win_q[2][2] <= px_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			flags_s2 <= '0;
		end else begin
			valid_s2 <= valid_s1 && flags_s1.emit;
			flags_s2 <= flags_s1;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sum[k] = '0;
		end
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (!((r == 0 && flags_s2.top_out) || (r == 2 && flags_s2.bottom_out) ||
					(c == 0 && flags_s2.left_out) || (c == 2 && flags_s2.right_out))) begin
					for (int k = 0; k < 3; k++) begin
						sum[k] = sum[k] + SUM_W'(win_q[r][c][k*CH_W +: CH_W]);
					end
				end
			end
		end
		for (int k = 0; k < 3; k++) begin
			prod[k] = (SUM_W+DIV9_SH)'(sum[k]) * (SUM_W+DIV9_SH)'(DIV9_MUL);
			res_data[k*CH_W +: CH_W] = prod[k][DIV9_SH +: CH_W];
		end
	end

	assign res_last = flags_s2.done;
	assign pending  = 2'(valid_s1 && flags_s1.emit) + 2'(valid_s2);

endmodule

// ----- src/bbr_out_fifo.sv -----
// Small result queue in front of the output stream.
module bbr_out_fifo import bbr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [PIX_W-1:0]     push_data,
	input  logic                 push_last,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [PIX_W-1:0]     out_data,
	output logic                 out_last,
	output logic [OUT_CNT_W-1:0] count
);
	logic [PIX_W:0]          buf_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0]    wr_ptr_q;
	logic [OUT_PTR_W-1:0]    rd_ptr_q;
	logic [OUT_CNT_W-1:0]    count_q;
	logic                    pop;

	assign out_valid = count_q != '0;
	assign pop       = out_valid && out_ready;
	assign out_data  = buf_q[rd_ptr_q][PIX_W-1:0];
	assign out_last  = buf_q[rd_ptr_q][PIX_W];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= {push_last, push_data};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
			end
			count_q <= count_q + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
		end
	end

endmodule

// ----- src/box_blur_3x3_rgb.sv -----
// Top level of the 3x3 box blur over a stream of 8-bit RGB pixels.
// Takes one pixel beat per clock in raster order while not held off and gives each
// pixel's 3x3 neighborhood sum per channel divided by nine, with pixels outside the
// frame counted as zero. A result passes through the line-store stage, the window
// registers and the output queue; the first result of a frame comes with pixel beat
// image_width+2, and image_width+1 flush beats after the last pixel drain the tail.
// Flush beats outside the tail are taken and dropped. Sustained rate is one
// beat per clock while the output takes results, set by the line-store read port
// and the output queue. After each configuration write the input holds off while
// a shift-subtract divider maps the output position onto the new width.
module box_blur_3x3_rgb import bbr_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [PIX_W-1:0]      s_axis_tdata,  // in_red, in_green, in_blue
	input  logic                  s_axis_tuser,  // kind
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [PIX_W-1:0]      m_axis_tdata,  // out_red, out_green, out_blue
	output logic                  m_axis_tlast
);
	localparam int COL_W = $clog2(MAX_WIDTH);

	logic                 slot_ok;
	logic                 proc;
	logic [COL_W-1:0]     col;
	logic [PIX_W-1:0]     px;
	win_flags_t           flags;
	logic                 valid_s1;
	logic [PIX_W-1:0]     up;
	logic [PIX_W-1:0]     mid;
	logic [PIX_W-1:0]     px_s1;
	win_flags_t           flags_s1;
	logic                 valid_s2;
	logic [PIX_W-1:0]     res_data;
	logic                 res_last;
	logic [1:0]           pending;
	logic [OUT_CNT_W-1:0] fifo_count;

	assign slot_ok = ((OUT_CNT_W+1)'(fifo_count) + (OUT_CNT_W+1)'(pending))
		< (OUT_CNT_W+1)'(OUT_DEPTH);

	bbr_ctrl #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (s_axis_tvalid),
		.in_kind  (s_axis_tuser),
		.in_pixel (s_axis_tdata),
		.slot_ok  (slot_ok),
		.in_ready (s_axis_tready),
		.proc     (proc),
		.col      (col),
		.px       (px),
		.flags    (flags)
	);

	bbr_line_buf #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_line_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.proc    (proc),
		.col     (col),
		.px      (px),
		.flags   (flags),
		.valid_s1(valid_s1),
		.up      (up),
		.mid     (mid),
		.px_s1   (px_s1),
		.flags_s1(flags_s1)
	);

	bbr_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_s1(valid_s1),
		.up      (up),
		.mid     (mid),
		.px_s1   (px_s1),
		.flags_s1(flags_s1),
		.valid_s2(valid_s2),
		.res_data(res_data),
		.res_last(res_last),
		.pending (pending)
	);

	bbr_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (valid_s2),
		.push_data(res_data),
		.push_last(res_last),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (m_axis_tdata),
		.out_last (m_axis_tlast),
		.count    (fifo_count)
	);

endmodule

// ----- tb/sv/box_blur_3x3_rgb_checker.sv -----
// Checker for the 3x3 RGB box blur: predicts each blurred pixel and compares the output beats.
module box_blur_3x3_rgb_checker import bbr_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [PIX_W-1:0]      s_axis_tdata,  // in_red, in_green, in_blue
	input  logic                  s_axis_tuser,  // kind
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [PIX_W-1:0]      m_axis_tdata,  // out_red, out_green, out_blue
	input  logic                  m_axis_tlast,
	output int                    fail_count,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} rgb_t;

	typedef struct {
		rgb_t pix;
		logic last;
	} blurred_t;

	logic [IMG_W_W-1:0] img_w;
	logic [IMG_H_W-1:0] img_h;
	rgb_t               older_row [MAX_WIDTH];
	rgb_t               prev_row [MAX_WIDTH];
	rgb_t               win [3][3];
	int unsigned        col_pos;
	int unsigned        row_pos;
	int unsigned        emit_pos;
	blurred_t           blurred_q [$];

	task automatic blur_pixel(input logic kind, input rgb_t px);
		int unsigned w, h, total, col, e, er, ec, sr, sg, sb;
		bit streaming, tail;
		rgb_t v;
		blurred_t res;
		w = (img_w < MIN_DIM) ? MIN_DIM : (img_w > MAX_WIDTH) ? MAX_WIDTH : img_w;
		h = (img_h < MIN_DIM) ? MIN_DIM : (img_h > MAX_HEIGHT) ? MAX_HEIGHT : img_h;
		total = w * h;
		col = (col_pos >= w) ? 0 : col_pos;
		streaming = (row_pos >= 2) || (row_pos == 1 && col >= 1);
		tail = streaming && (emit_pos + w + 1 >= total);
		if (kind == KIND_FLUSH && !tail)
			return;
		if (kind == KIND_FLUSH)
			px = '0;
		for (int r = 0; r < 3; r++) begin
			win[r][0] = win[r][1];
			win[r][1] = win[r][2];
		end
		win[0][2] = older_row[col];
		win[1][2] = prev_row[col];
		win[2][2] = px;
		older_row[col] = prev_row[col];
		prev_row[col] = px;
		if (col + 1 >= w) begin
			col_pos = 0;
			if (row_pos < MAX_HEIGHT - 1)
				row_pos++;
		end else begin
			col_pos = col + 1;
		end
		if (!streaming)
			return;
		e = emit_pos;
		ec = e % w;
		er = e / w;
		sr = 0;
		sg = 0;
		sb = 0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (!((r == 0 && er == 0) || (r == 2 && er + 1 >= h) ||
				      (c == 0 && ec == 0) || (c == 2 && ec + 1 >= w))) begin
					v = win[r][c];
					sr += v.red;
					sg += v.green;
					sb += v.blue;
				end
			end
		end
		res.pix.red   = CH_W'(sr / 9);
		res.pix.green = CH_W'(sg / 9);
		res.pix.blue  = CH_W'(sb / 9);
		res.last = (e + 1 >= total);
		if (res.last) begin
			col_pos = 0;
			row_pos = 0;
			emit_pos = 0;
		end else begin
			emit_pos = e + 1;
		end
		blurred_q.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		rgb_t seen;
		blurred_t want;
		if (!arst_n) begin
			img_w = WIDTH_RESET;
			img_h = HEIGHT_RESET;
			for (int i = 0; i < MAX_WIDTH; i++) begin
				older_row[i] = '0;
				prev_row[i] = '0;
			end
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					win[r][c] = '0;
			col_pos = 0;
			row_pos = 0;
			emit_pos = 0;
			blurred_q.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_IDX_WIDTH)
					img_w = cfg_data[IMG_W_W-1:0];
				else
					img_h = cfg_data;
			end
			if (s_axis_tvalid && s_axis_tready)
				blur_pixel(s_axis_tuser, s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				if (blurred_q.size() == 0) begin
					$error("output beat with no result pending");
					fail_count++;
				end else begin
					want = blurred_q.pop_front();
					seen = m_axis_tdata;
					if (seen.red !== want.pix.red) begin
						$error("out_red: expected %0d, got %0d", want.pix.red, seen.red);
						fail_count++;
					end
					if (seen.green !== want.pix.green) begin
						$error("out_green: expected %0d, got %0d", want.pix.green, seen.green);
						fail_count++;
					end
					if (seen.blue !== want.pix.blue) begin
						$error("out_blue: expected %0d, got %0d", want.pix.blue, seen.blue);
						fail_count++;
					end
					if (m_axis_tlast !== want.last) begin
						$error("frame_done: expected %0b, got %0b", want.last, m_axis_tlast);
						fail_count++;
					end
				end
			end
			pending <= blurred_q.size();
		end
	end

endmodule

// ----- tb/sv/box_blur_3x3_rgb_tb.sv -----
// Top of the box blur testbench: clock, reset, frame stimulus, output stalls and verdict.
module box_blur_3x3_rgb_tb import bbr_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_WIDTH    = 1024;
	localparam int RANDOM_ITEMS = 500;
	localparam int WIDE_ITEMS   = 1030;
	localparam int TALL_ITEMS   = 30;
	localparam int CYCLE_LIMIT  = 2_000_000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic                  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [PIX_W-1:0]      s_axis_tdata;  // in_red, in_green, in_blue
	logic                  s_axis_tuser;  // kind
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [PIX_W-1:0]      m_axis_tdata;  // out_red, out_green, out_blue
	logic                  m_axis_tlast;
	int                    fail_count;
	int                    pending;
	int                    cycles;
	int                    burst_left;
	int                    items;
	int                    frame_w;
	int                    frame_h;

	box_blur_3x3_rgb #(.MAX_WIDTH(MAX_WIDTH)) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	box_blur_3x3_rgb_checker #(.MAX_WIDTH(MAX_WIDTH)) blur_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("box_blur_3x3_rgb_tb: FAIL");
			$finish;
		end
	end

	function automatic logic [PIX_W-1:0] rand_pixel();
		logic [PIX_W-1:0] px;
		for (int k = 0; k < 3; k++) begin
			case ($urandom_range(0, 5))
				0:       px[k*CH_W +: CH_W] = '0;
				1:       px[k*CH_W +: CH_W] = '1;
				default: px[k*CH_W +: CH_W] = CH_W'($urandom);
			endcase
		end
		return px;
	endfunction

	task automatic send_beat(input logic kind, input logic [PIX_W-1:0] px);
		int gap;
		if (burst_left == 0) begin
			case ($urandom_range(0, 7))
				0:       gap = $urandom_range(5, 20);
				1, 2:    gap = 0;
				default: gap = $urandom_range(1, 3);
			endcase
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
			                                          : $urandom_range(1, 16);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		s_axis_tuser  <= kind;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		burst_left--;
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_regs(input logic [CFG_DATA_W-1:0] width_val,
	                          input logic [CFG_DATA_W-1:0] height_val);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_IDX_WIDTH;
		cfg_data  <= width_val;
		@(posedge clk);
		cfg_index <= CFG_IDX_HEIGHT;
		cfg_data  <= height_val;
		@(posedge clk);
		cfg_we <= 1'b0;
		frame_w = width_val[IMG_W_W-1:0];
		frame_w = (frame_w < MIN_DIM) ? MIN_DIM : (frame_w > MAX_WIDTH) ? MAX_WIDTH : frame_w;
		frame_h = height_val;
		frame_h = (frame_h < MIN_DIM) ? MIN_DIM : (frame_h > MAX_HEIGHT) ? MAX_HEIGHT : frame_h;
	endtask

	task automatic run_frame(input int noise_pct);
		for (int i = 0; i < frame_w * frame_h; i++) begin
			if ($urandom_range(0, 99) < noise_pct)
				send_beat(KIND_FLUSH, rand_pixel());
			send_beat(KIND_PIXEL, rand_pixel());
			items++;
		end
		for (int i = 0; i <= frame_w; i++) begin
			send_beat(($urandom_range(0, 2) == 0) ? KIND_PIXEL : KIND_FLUSH, rand_pixel());
			items++;
		end
		if ($urandom_range(0, 3) == 0)
			send_beat(KIND_FLUSH, rand_pixel());
	endtask

	initial begin : sink_pattern
		int mode;
		int run_len;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		// hold off long enough for the block to back up into its input
		@(posedge clk);
		m_axis_tready <= 1'b0;
		repeat (400) @(posedge clk);
		repeat (1500) begin
			@(posedge clk);
			m_axis_tready <= 1'($urandom_range(0, 1));
		end
		forever begin
			mode = $urandom_range(0, 3);
			run_len = $urandom_range(1, 120);
			repeat (run_len) begin
				@(posedge clk);
				case (mode)
					0:       m_axis_tready <= 1'b1;
					1:       m_axis_tready <= 1'($urandom_range(0, 1));
					2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		logic [PIX_W-1:0] corner_px [9];
		logic [CFG_DATA_W-1:0] wv;
		logic [CFG_DATA_W-1:0] hv;
		corner_px = '{24'hFFFFFF, 24'h000000, 24'h0000FF, 24'h00FF00, 24'hFF0000,
		              24'hFFFFFF, 24'h808080, 24'h7F7F7F, 24'hFFFFFF};
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= CFG_IDX_WIDTH;
		cfg_data      <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= KIND_PIXEL;
		burst_left = 0;
		items = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// smallest frame: extreme pixels, stray flushes, pixels in the tail
		write_regs(3, 3);
		send_beat(KIND_FLUSH, 24'hFFFFFF);
		for (int i = 0; i < 9; i++) begin
			if (i == 4)
				send_beat(KIND_FLUSH, 24'h000000);
			send_beat(KIND_PIXEL, corner_px[i]);
		end
		send_beat(KIND_PIXEL, 24'hFFFFFF);
		send_beat(KIND_FLUSH, 24'h000000);
		send_beat(KIND_PIXEL, 24'h000000);
		send_beat(KIND_FLUSH, 24'hFFFFFF);
		send_beat(KIND_FLUSH, 24'h000000);

		while (items < RANDOM_ITEMS) begin
			wait_idle();
			case ($urandom_range(0, 9))
				0:       wv = $urandom_range(0, 2);
				1:       wv = $urandom_range(9, 40);
				2:       wv = CFG_DATA_W'($urandom_range(3, 8)) |
				              (CFG_DATA_W'($urandom_range(1, 3)) << IMG_W_W);
				default: wv = $urandom_range(3, 8);
			endcase
			case ($urandom_range(0, 7))
				0:       hv = $urandom_range(0, 2);
				1:       hv = $urandom_range(7, 12);
				default: hv = $urandom_range(3, 6);
			endcase
			write_regs(wv, hv);
			repeat ($urandom_range(1, 2)) run_frame(8);
		end

		// widest row, then narrow the frame into its second row and drain it
		wait_idle();
		write_regs(13'd2047, 13'd3);
		for (int i = 0; i < WIDE_ITEMS; i++) begin
			send_beat(KIND_PIXEL, rand_pixel());
			items++;
		end
		wait_idle();
		write_regs(13'd3, 13'd3);
		send_beat(KIND_PIXEL, rand_pixel());
		for (int i = 0; i < 4; i++) begin
			send_beat(($urandom_range(0, 1) == 0) ? KIND_PIXEL : KIND_FLUSH, rand_pixel());
			items++;
		end

		// tallest height with masked high width bits, then shrink and drain
		wait_idle();
		write_regs(13'h1800, 13'h1FFF);
		for (int i = 0; i < TALL_ITEMS; i++) begin
			send_beat(KIND_PIXEL, rand_pixel());
			items++;
		end
		wait_idle();
		write_regs(13'd3, 13'd3);
		send_beat(($urandom_range(0, 1) == 0) ? KIND_PIXEL : KIND_FLUSH, rand_pixel());

		wait_idle();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("box_blur_3x3_rgb_tb: PASS");
		end else begin
			$display("box_blur_3x3_rgb_tb: FAIL");
		end
		$finish;
	end

endmodule
